FILE: rtl/sliding_window_sum_min_max_top_macros.svh
// Assertion macros shared by the sliding window sum RTL.
// Needs a clock named clk and a synchronous active-low reset named rst_n in scope.
`ifndef SLIDING_WINDOW_SUM_MIN_MAX_TOP_MACROS_SVH
`define SLIDING_WINDOW_SUM_MIN_MAX_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SWSMM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWSMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/swsmm_pkg.sv
// Shared types and constants of the sliding window sum block.
// No dependencies.
`default_nettype none

package swsmm_pkg;

  localparam int CFG_BITS   = 11;
  localparam int SUM_BITS   = 34;
  localparam int TOTAL_BITS = 48;

  localparam logic [CFG_BITS-1:0] CFG_LEN_RESET = 11'd128;

  typedef logic [CFG_BITS-1:0]   cfg_len_t;
  typedef logic [SUM_BITS-1:0]   sum_t;
  typedef logic [TOTAL_BITS-1:0] total_t;

  // Per-word control decided by the front end.
  typedef struct packed {
    logic sub_old;   // window already full: drop the oldest sample
    logic fill_now;  // this word completes the first fill
  } swsmm_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/swsmm_if.sv
// Valid/ready channel interfaces for sample words and result words.
// Depends on swsmm_pkg.
`default_nettype none

interface swsmm_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface swsmm_out_if;
  logic                  valid;
  logic                  ready;
  logic                  window_full;
  swsmm_pkg::sum_t       window_sum;
  swsmm_pkg::sum_t       largest_sum;
  swsmm_pkg::sum_t       smallest_sum;
  swsmm_pkg::total_t     total_sum;

  modport source (output valid, output window_full, output window_sum, output largest_sum,
                  output smallest_sum, output total_sum, input ready);
  modport sink   (input valid, input window_full, input window_sum, input largest_sum,
                  input smallest_sum, input total_sum, output ready);
endinterface

`default_nettype wire

FILE: rtl/sliding_window_sum_min_max_top.sv
// Channel     Dir  Payload                                                   Handshake
// in_ch       in   sample_value                                              valid/ready
// out_ch      out  window_full, window_sum, largest_sum, smallest_sum, total  valid/ready
// cfg_*       in   cfg_wdata (window length)                                 cfg_we
//
// Sustained rate is one word per cycle while out_ch is not stalled; a result passes the sample
// RAM read, the queue and the sum/min/max result register before it can leave.
// The sample RAM takes one read and one write per word, which sets the one-per-cycle rate.
// Reset is synchronous, active low, with no clearing pass; the window length is latched
// from cfg_wdata's register on the first word after reset. Each side stalls on its own
// through the two-entry queue and the result register.
// Depends on swsmm_pkg, swsmm_if, swsmm_front, swsmm_fifo and swsmm_back.
`default_nettype none

module sliding_window_sum_min_max_top #(
  parameter int WINDOW_MAX  = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire swsmm_pkg::cfg_len_t cfg_wdata,
  swsmm_in_if.sink                 in_ch,
  swsmm_out_if.source              out_ch
);
  import swsmm_pkg::*;

  localparam int CTL_BITS = $bits(swsmm_ctl_t);
  localparam int Q_BITS   = 2 * SAMPLE_BITS + CTL_BITS;

  logic                   push_valid;
  logic                   push_ready;
  logic [SAMPLE_BITS-1:0] push_sample;
  logic [SAMPLE_BITS-1:0] push_old;
  swsmm_ctl_t             push_ctl;
  logic                   pop_valid;
  logic                   pop_ready;
  logic [Q_BITS-1:0]      pop_data;
  swsmm_ctl_t             pop_ctl;

  swsmm_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_sample (push_sample),
    .push_old    (push_old),
    .push_ctl    (push_ctl)
  );

  swsmm_fifo #(
    .WIDTH (Q_BITS)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_sample, push_old, push_ctl}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_ctl = swsmm_ctl_t'(pop_data[CTL_BITS-1:0]);

  swsmm_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_sample (pop_data[Q_BITS-1 -: SAMPLE_BITS]),
    .pop_old    (pop_data[CTL_BITS +: SAMPLE_BITS]),
    .pop_ctl    (pop_ctl),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/swsmm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-first on an address collision. No dependencies.
`default_nettype none

module swsmm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/swsmm_front.sv
// Front end: window length register, ring position, fill tracking and the sample RAM.
// Depends on swsmm_pkg, swsmm_if and swsmm_ram.
`default_nettype none

module swsmm_front #(
  parameter int WINDOW_MAX  = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire swsmm_pkg::cfg_len_t    cfg_wdata,
  swsmm_in_if.sink                    in_ch,
  output logic                        push_valid,
  input  wire logic                   push_ready,
  output logic [SAMPLE_BITS-1:0]      push_sample,
  output logic [SAMPLE_BITS-1:0]      push_old,
  output swsmm_pkg::swsmm_ctl_t       push_ctl
);
  import swsmm_pkg::*;

  localparam int AW = $clog2(WINDOW_MAX);

  cfg_len_t               len_reg_r;
  logic                   latched_r;
  logic [AW-1:0]          last_r;
  logic [AW-1:0]          last_cfg;
  logic [AW-1:0]          last_eff;
  logic [AW-1:0]          pos_r;
  logic [AW-1:0]          pos_nxt;
  logic                   filled_r;
  logic                   filled_nxt;
  logic                   at_end;
  logic                   accept;
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  swsmm_ctl_t             s1_ctl_r;

  // Zero length acts as one, long lengths clip to the store depth.
  always_comb begin
    if (len_reg_r == '0) begin
      last_cfg = '0;
    end else if (32'(len_reg_r) > 32'(WINDOW_MAX)) begin
      last_cfg = AW'(WINDOW_MAX - 1);
    end else begin
      last_cfg = AW'(len_reg_r - 1'b1);
    end
  end

  assign last_eff   = latched_r ? last_r : last_cfg;
  assign at_end     = (pos_r == last_eff);
  assign pos_nxt    = at_end ? '0 : pos_r + 1'b1;
  assign filled_nxt = filled_r | at_end;

  assign in_ch.ready = !s1_valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_reg_r <= CFG_LEN_RESET;
    end else if (cfg_we) begin
      len_reg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= 1'b0;
      last_r    <= '0;
      pos_r     <= '0;
      filled_r  <= 1'b0;
    end else if (accept) begin
      latched_r <= 1'b1;
      last_r    <= last_eff;
      pos_r     <= pos_nxt;
      filled_r  <= filled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r       <= in_ch.sample_value;
      s1_ctl_r.sub_old  <= filled_r;
      s1_ctl_r.fill_now <= !filled_r && at_end;
    end
  end

  // Read the oldest sample and overwrite it with the new one in the same cycle.
  swsmm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (pos_r),
    .wdata (in_ch.sample_value),
    .re    (accept),
    .raddr (pos_r),
    .rdata (push_old)
  );

  assign push_valid  = s1_valid_r;
  assign push_sample = s1_sample_r;
  assign push_ctl    = s1_ctl_r;

endmodule

`default_nettype wire

FILE: rtl/swsmm_fifo.sv
// Two-entry word queue between front end and back end.
// No dependencies.
`default_nettype none

module swsmm_fifo #(
  parameter int WIDTH = 50
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/swsmm_back.sv
// Back end: window sum update, min/max tracking, saturating total and result register.
// Depends on swsmm_pkg, swsmm_if and the assertion macro header.
`default_nettype none
`include "sliding_window_sum_min_max_top_macros.svh"

module swsmm_back #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   pop_valid,
  output logic                        pop_ready,
  input  wire logic [SAMPLE_BITS-1:0] pop_sample,
  input  wire logic [SAMPLE_BITS-1:0] pop_old,
  input  wire swsmm_pkg::swsmm_ctl_t  pop_ctl,
  swsmm_out_if.source                 out_ch
);
  import swsmm_pkg::*;

  sum_t                sum_r;
  sum_t                sum_nxt;
  sum_t                max_r;
  sum_t                max_nxt;
  sum_t                min_r;
  sum_t                min_nxt;
  total_t              total_r;
  total_t              total_nxt;
  logic [TOTAL_BITS:0] total_wide;
  sum_t                drop;
  logic                full_nxt;
  logic                pop;
  logic                out_valid_r;
  logic                out_full_r;
  sum_t                out_sum_r;
  sum_t                out_max_r;
  sum_t                out_min_r;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign pop       = pop_valid && pop_ready;

  assign drop     = pop_ctl.sub_old ? SUM_BITS'(pop_old) : '0;
  assign sum_nxt  = sum_r + SUM_BITS'(pop_sample) - drop;
  assign full_nxt = pop_ctl.sub_old || pop_ctl.fill_now;

  always_comb begin
    max_nxt = max_r;
    min_nxt = min_r;
    if (pop_ctl.fill_now) begin
      max_nxt = sum_nxt;
      min_nxt = sum_nxt;
    end else if (pop_ctl.sub_old) begin
      if (sum_nxt > max_r) begin
        max_nxt = sum_nxt;
      end
      if (sum_nxt < min_r) begin
        min_nxt = sum_nxt;
      end
    end
  end

  // Clip the total at all ones on carry out.
  assign total_wide = {1'b0, total_r} + (TOTAL_BITS + 1)'(pop_sample);
  assign total_nxt  = total_wide[TOTAL_BITS] ? '1 : total_wide[TOTAL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      max_r   <= '0;
      min_r   <= '0;
      total_r <= '0;
    end else if (pop) begin
      sum_r   <= sum_nxt;
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_ready) begin
      out_valid_r <= pop_valid;
    end
  end

  // Sums read zero until the window has filled.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_full_r <= full_nxt;
      out_sum_r  <= full_nxt ? sum_nxt : '0;
      out_max_r  <= full_nxt ? max_nxt : '0;
      out_min_r  <= full_nxt ? min_nxt : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.window_full  = out_full_r;
  assign out_ch.window_sum   = out_sum_r;
  assign out_ch.largest_sum  = out_max_r;
  assign out_ch.smallest_sum = out_min_r;
  assign out_ch.total_sum    = total_r;

  `SWSMM_ASSERT_IMPL(a_max_ge_min, out_valid_r && out_full_r, out_max_r >= out_min_r,
                     "largest window sum below smallest")
  `SWSMM_ASSERT_IMPL(a_zero_before_full, out_valid_r && !out_full_r,
                     out_sum_r == '0 && out_max_r == '0 && out_min_r == '0,
                     "window sums nonzero before first fill")
  `SWSMM_ASSERT_NEXT(a_total_monotonic, pop, total_r >= $past(total_r),
                     "running total decreased")
  `SWSMM_ASSERT_NEXT(a_fill_sets_extremes, pop && pop_ctl.fill_now,
                     max_r == sum_r && min_r == sum_r,
                     "first fill did not seed min and max")

endmodule

`default_nettype wire

FILE: tb/sliding_window_sum_min_max_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_sum_min_max_top: random valid/ready traffic,
// a per-word predictor of window sum, min/max and saturating total, in-order checking.
// Depends on swsmm_pkg, swsmm_if and the RTL of the block.
`default_nettype none

module sliding_window_sum_min_max_top_tb;
  import swsmm_pkg::*;

  localparam int          WIN_MAX      = 1024;
  localparam int          SMP_BITS     = 24;
  localparam int          PIPE_CYCLES  = 3;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          BASE_ITEMS   = 800;
  localparam logic [23:0] SAMPLE_TOP   = 24'hFFFFFF;
  localparam total_t      TOTAL_TOP    = {TOTAL_BITS{1'b1}};

  typedef struct packed {
    logic   full;
    sum_t   wsum;
    sum_t   big;
    sum_t   tiny;
    total_t tot;
  } window_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_len_t cfg_wdata;

  swsmm_in_if #(.SAMPLE_BITS(SMP_BITS)) in_ch ();
  swsmm_out_if out_ch ();

  sliding_window_sum_min_max_top #(
    .WINDOW_MAX (WIN_MAX),
    .SAMPLE_BITS(SMP_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Window model state
  logic [SMP_BITS-1:0] ring_samples [WIN_MAX];
  int unsigned         ring_wr_pos;
  logic                ring_filled;
  sum_t                run_window_sum;
  sum_t                peak_sum;
  sum_t                floor_sum;
  total_t              grand_sum;
  cfg_len_t            len_register;
  int unsigned         len_in_force;
  logic                len_locked;

  logic [SMP_BITS-1:0] sample_queue [$];
  window_result_t      expected_windows [$];

  int  samples_accepted;
  int  driver_seen_accepted;
  int  windows_checked;
  int  mismatch_count;
  int  full_windows_seen;
  int  cycle_count;
  int  send_idle_pct;
  int  recv_stall_pct;
  logic recv_hold;

  function automatic void clear_window_model();
    ring_wr_pos    = 0;
    ring_filled    = 1'b0;
    run_window_sum = '0;
    peak_sum       = '0;
    floor_sum      = '0;
    grand_sum      = '0;
    len_register   = CFG_LEN_RESET;
    len_in_force   = 1;
    len_locked     = 1'b0;
  endfunction

  // Advance the window by one sample and queue the word the block should return.
  function automatic void advance_window(input logic [SMP_BITS-1:0] smp);
    int unsigned    pos;
    int unsigned    nxt;
    window_result_t res;
    total_t         wide;
    if (!len_locked) begin
      if (len_register == 0) len_in_force = 1;
      else if (len_register > WIN_MAX) len_in_force = WIN_MAX;
      else len_in_force = len_register;
      len_locked = 1'b1;
    end
    pos = ring_wr_pos;
    if (pos >= len_in_force) pos = 0;
    nxt = pos + 1;
    if (nxt >= len_in_force) nxt = 0;
    if (ring_filled) begin
      run_window_sum = run_window_sum - sum_t'(ring_samples[pos]) + sum_t'(smp);
      if (run_window_sum > peak_sum) peak_sum = run_window_sum;
      if (run_window_sum < floor_sum) floor_sum = run_window_sum;
    end else begin
      run_window_sum = run_window_sum + sum_t'(smp);
    end
    ring_samples[pos] = smp;
    ring_wr_pos = nxt;
    wide = total_t'(smp);
    if (grand_sum > TOTAL_TOP - wide) grand_sum = TOTAL_TOP;
    else grand_sum = grand_sum + wide;
    if (!ring_filled && nxt == 0) begin
      ring_filled = 1'b1;
      peak_sum    = run_window_sum;
      floor_sum   = run_window_sum;
    end
    res.full = ring_filled;
    res.wsum = ring_filled ? run_window_sum : '0;
    res.big  = ring_filled ? peak_sum : '0;
    res.tiny = ring_filled ? floor_sum : '0;
    res.tot  = grand_sum;
    expected_windows.push_back(res);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still expected", cycle_count,
               expected_windows.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Input side: take the accepted word into the model, drop it from the queue.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      advance_window(in_ch.sample_value);
      void'(sample_queue.pop_front());
      samples_accepted = samples_accepted + 1;
    end
  end

  // Result side: compare against the oldest expected word.
  always @(posedge clk) begin
    window_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      windows_checked = windows_checked + 1;
      if (out_ch.window_full) full_windows_seen = full_windows_seen + 1;
      if (expected_windows.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result word: full=%0b sum=%0h total=%0h", $realtime,
                   out_ch.window_full, out_ch.window_sum, out_ch.total_sum);
      end else begin
        want = expected_windows.pop_front();
        if (out_ch.window_full !== want.full || out_ch.window_sum !== want.wsum ||
            out_ch.largest_sum !== want.big || out_ch.smallest_sum !== want.tiny ||
            out_ch.total_sum !== want.tot) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("[%0t] word %0d: full exp %0b got %0b, sum exp %0h got %0h", $realtime,
                     windows_checked, want.full, out_ch.window_full, want.wsum,
                     out_ch.window_sum);
            $display("  largest exp %0h got %0h, smallest exp %0h got %0h, total exp %0h got %0h",
                     want.big, out_ch.largest_sum, want.tiny, out_ch.smallest_sum, want.tot,
                     out_ch.total_sum);
          end
        end
      end
    end
  end

  // Sample driver: hold the word until accepted, then present the next one or idle.
  always @(negedge clk) begin
    if (!in_ch.valid || samples_accepted != driver_seen_accepted) begin
      driver_seen_accepted = samples_accepted;
      if (rst_n && sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= sample_queue[0];
      end else begin
        in_ch.valid        <= 1'b0;
        in_ch.sample_value <= SMP_BITS'($urandom);
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off, counted here; released on a rising edge.
  always begin
    wait (recv_hold);
    repeat (HOLD_CYCLES) @(posedge clk);
    recv_hold = 1'b0;
  end

  task automatic write_length(input cfg_len_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    // Register updates; the length in force stays latched until the next reset.
    len_register = val;
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || expected_windows.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 3) @(negedge clk);
  endtask

  // Runs at varying levels so window sums climb and fall and min/max move.
  task automatic queue_random_samples(input int count, input int win);
    int          made;
    int          run;
    int          mode;
    logic [23:0] level;
    logic [23:0] jitter;
    made = 0;
    while (made < count) begin
      mode  = $urandom_range(9);
      run   = $urandom_range(1, 2 * win + 2);
      level = 24'($urandom);
      jitter = 24'($urandom_range(0, 255));
      repeat (run) begin
        if (made < count) begin
          case (mode)
            0: sample_queue.push_back('0);
            1: sample_queue.push_back(SAMPLE_TOP);
            2, 3: sample_queue.push_back(24'($urandom));
            default: sample_queue.push_back(level ^ (24'($urandom) & {16'd0, jitter[7:0]}));
          endcase
          made = made + 1;
        end
      end
    end
  endtask

  initial begin
    int          phase_send [4];
    int          phase_stall [4];
    int          random_items;
    int          per_phase;
    int          win_eff;
    cfg_len_t    chosen_len;
    logic [23:0] directed [$];

    phase_send  = '{0, 70, 0, 13};
    phase_stall = '{0, 0, 70, 13};
    samples_accepted     = 0;
    driver_seen_accepted = 0;
    windows_checked      = 0;
    mismatch_count       = 0;
    full_windows_seen    = 0;
    cycle_count          = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    recv_hold            = 1'b0;
    clear_window_model();

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.sample_value = '0;
    out_ch.ready       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Only the value in the register at the first sample counts; try both extremes first.
    case ($urandom_range(6))
      0: chosen_len = 11'd0;
      1: chosen_len = 11'd1;
      2: chosen_len = 11'd2;
      3: chosen_len = cfg_len_t'($urandom_range(3, 16));
      4: chosen_len = cfg_len_t'($urandom_range(17, 300));
      5: chosen_len = 11'd1024;
      default: chosen_len = 11'd2047;
    endcase
    write_length(11'd0);
    write_length(11'd2047);
    write_length(chosen_len);
    win_eff = (chosen_len == 0) ? 1 : (chosen_len > WIN_MAX) ? WIN_MAX : chosen_len;
    // Long windows get just enough extra words to fill and then slide for a while.
    random_items = (win_eff + 100 > BASE_ITEMS) ? win_eff + 100 : BASE_ITEMS;
    per_phase = random_items / 4;

    directed = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000001, 24'h800000, 24'h555555,
                 24'hAAAAAA, 24'h000000, 24'h000000, 24'hFFFFFF, 24'h7FFFFF, 24'h000000,
                 24'hFFFFFE, 24'h000000, 24'h123456, 24'hFFFFFF};
    foreach (directed[i]) sample_queue.push_back(directed[i]);
    wait_drained();
    // Late write: must leave the latched window alone.
    write_length(11'd1);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_stall[ph];
      queue_random_samples(per_phase, win_eff);
      if (ph == 0) begin
        // Hold the receiver while the sender keeps pushing, so the block backs up.
        @(posedge clk);
        recv_hold = 1'b1;
        queue_random_samples(40, win_eff);
      end
      wait_drained();
      write_length(cfg_len_t'($urandom_range(0, 2047)));
    end
    write_length(11'd1024);

    wait_drained();
    $display("Window of %0d samples latched from register value %0d; register rewritten later.",
             win_eff, chosen_len);
    $display("Checked %0d result words (%0d with a full window) over four handshake profiles.",
             windows_checked, full_windows_seen);
    if (mismatch_count == 0 && expected_windows.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching words", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
